// ----- design/shadow_memory_poison_checker_unit_assert.svh -----
// Assertion macros used by the shadow memory poison checker top level.
// Depends on nothing; include by bare file name.
`ifndef SHADOW_MEMORY_POISON_CHECKER_UNIT_ASSERT_SVH
`define SHADOW_MEMORY_POISON_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SMPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/smpc_pkg.sv -----
// Shared constants, codes and types of the shadow memory poison checker.
// Depends on nothing.
package smpc_pkg;

  localparam int ADDR_W        = 64;
  localparam int LEN_W         = 21;
  localparam int VAL_W         = 8;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;

  localparam int WINDOW_BYTES  = 1048576;
  localparam int GRANULE_BYTES = 8;
  localparam int DEPTH         = WINDOW_BYTES / GRANULE_BYTES;
  localparam int WIN_W         = $clog2(WINDOW_BYTES);
  localparam int GRAN_W        = $clog2(GRANULE_BYTES);
  localparam int IDX_W         = WIN_W - GRAN_W;
  localparam int CNT_W         = GRAN_W + 1;
  localparam int FCNT_W        = LEN_W - GRAN_W;
  localparam int CMP_W         = VAL_W + 1;

  // Operation codes; the fourth code does nothing.
  localparam logic [OP_W-1:0] OP_POISON   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNPOISON = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FOUND  = 2'd1;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

  // One shadow entry to test: its value, position of the first byte in the
  // granule, and how many consecutive bytes of the range fall in it.
  typedef struct packed {
    logic signed [VAL_W-1:0] shadow;
    logic [GRAN_W-1:0]       pos0;
    logic [CNT_W-1:0]        cnt;
  } smpc_gran_req_t;

  typedef struct packed {
    logic              hit;
    logic [GRAN_W-1:0] idx;
  } smpc_hit_t;

endpackage

// ----- design/smpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module smpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/smpc_granule_test.sv -----
// Tests the bytes of one granule against its shadow value; the lowest poisoned byte wins.
// Depends on smpc_pkg.
module smpc_granule_test (
  input  smpc_pkg::smpc_gran_req_t req,
  output smpc_pkg::smpc_hit_t      res
);

  always_comb begin
    logic [smpc_pkg::GRAN_W-1:0] pos;
    logic                        bad;
    res.hit = 1'b0;
    res.idx = '0;
    // Walk down so the lowest poisoned byte wins.
    for (int i = smpc_pkg::GRANULE_BYTES - 1; i >= 0; i--) begin
      pos = req.pos0 + smpc_pkg::GRAN_W'(i);
      bad = (req.shadow != '0) &&
            ($signed({{(smpc_pkg::CMP_W - smpc_pkg::GRAN_W){1'b0}}, pos}) >=
             $signed({req.shadow[smpc_pkg::VAL_W-1], req.shadow}));
      if ((smpc_pkg::CNT_W'(i) < req.cnt) && bad) begin
        res.hit = 1'b1;
        res.idx = smpc_pkg::GRAN_W'(i);
      end
    end
  end

endmodule

// ----- design/shadow_memory_poison_checker_unit.sv -----
// Top level of the shadow memory poison checker: sequencer, shadow RAM and
// granule test unit. Depends on smpc_pkg, smpc_ram, smpc_granule_test and the assert header.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready   | operation, address, length, value
//  out     | output    | out_valid / out_ready | status, poisoned_address
//  cfg     | input     | cfg_wr_en only        | window_base (64 bits)
//
// After reset a clearing pass zeroes the shadow RAM, one entry a cycle, over all DEPTH
// entries (131072 at the default window); no item is taken meanwhile.
// An item passes through accept, setup and range-check steps (S_IDLE, S_PREP, S_EVAL,
// S_DECIDE), then a fill of one shadow entry a cycle or a check walk that reads one
// entry a cycle while the previous one is tested, and a load of the output register.
// The one RAM and the one granule test unit set that rate. A result still held in the
// output register stalls the load step, and no new item is taken until it moves.
module shadow_memory_poison_checker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [smpc_pkg::ADDR_W-1:0]         cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [smpc_pkg::OP_W-1:0]           in_operation,
  input  logic [smpc_pkg::ADDR_W-1:0]         in_address,
  input  logic [smpc_pkg::LEN_W-1:0]          in_length,
  input  logic signed [smpc_pkg::VAL_W-1:0]   in_poison_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [smpc_pkg::ST_W-1:0]           out_status,
  output logic [smpc_pkg::ADDR_W-1:0]         out_poisoned_address
);

`include "shadow_memory_poison_checker_unit_assert.svh"

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PREP, S_EVAL, S_DECIDE, S_FILL, S_SCAN, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  logic [smpc_pkg::ADDR_W-1:0]       window_base_r, window_base_nxt;
  logic [smpc_pkg::IDX_W-1:0]        clr_idx_r, clr_idx_nxt;

  // Request as taken.
  logic [smpc_pkg::OP_W-1:0]         req_op_r, req_op_nxt;
  logic [smpc_pkg::ADDR_W-1:0]       req_addr_r, req_addr_nxt;
  logic [smpc_pkg::LEN_W-1:0]        req_len_r, req_len_nxt;
  logic signed [smpc_pkg::VAL_W-1:0] req_pv_r, req_pv_nxt;

  // Range arithmetic.
  logic [smpc_pkg::ADDR_W-1:0]       off_a_r, off_a_nxt;
  logic [smpc_pkg::ADDR_W-1:0]       end_r, end_nxt;
  logic [smpc_pkg::ADDR_W-1:0]       off_e_r, off_e_nxt;

  // Fill walk.
  logic [smpc_pkg::IDX_W-1:0]        fill_idx_r, fill_idx_nxt;
  logic [smpc_pkg::FCNT_W-1:0]       fill_cnt_r, fill_cnt_nxt;
  logic [smpc_pkg::VAL_W-1:0]        fill_val_r, fill_val_nxt;

  // Check walk: issue side and test side.
  logic [smpc_pkg::ADDR_W-1:0]       iss_addr_r, iss_addr_nxt;
  logic [smpc_pkg::WIN_W-1:0]        iss_off_r, iss_off_nxt;
  logic [smpc_pkg::LEN_W-1:0]        iss_rem_r, iss_rem_nxt;
  logic                              t_valid_r, t_valid_nxt;
  logic [smpc_pkg::ADDR_W-1:0]       t_addr_r, t_addr_nxt;
  logic [smpc_pkg::CNT_W-1:0]        t_cnt_r, t_cnt_nxt;
  logic                              t_last_r, t_last_nxt;

  // Result waiting for the output register, and the output register.
  logic [smpc_pkg::ST_W-1:0]         res_status_r, res_status_nxt;
  logic [smpc_pkg::ADDR_W-1:0]       res_addr_r, res_addr_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [smpc_pkg::ST_W-1:0]         out_status_r, out_status_nxt;
  logic [smpc_pkg::ADDR_W-1:0]       out_addr_r, out_addr_nxt;

  // RAM port.
  logic                              ram_we;
  logic [smpc_pkg::IDX_W-1:0]        ram_waddr;
  logic [smpc_pkg::VAL_W-1:0]        ram_wdata;
  logic [smpc_pkg::VAL_W-1:0]        ram_rdata;

  smpc_pkg::smpc_gran_req_t          gt_req;
  smpc_pkg::smpc_hit_t               gt_res;

  logic                              in_acc;
  logic [smpc_pkg::ADDR_W-1:0]       off_l;
  logic                              a_in, e_in, l_in, aligned;
  logic [smpc_pkg::CNT_W-1:0]        room, cnt;
  logic                              rem_fits;

  smpc_ram #(
    .WIDTH (smpc_pkg::VAL_W),
    .DEPTH (smpc_pkg::DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss_off_r[smpc_pkg::WIN_W-1:smpc_pkg::GRAN_W]),
    .rdata (ram_rdata)
  );

  smpc_granule_test u_test (
    .req (gt_req),
    .res (gt_res)
  );

  assign in_ready             = (state_r == S_IDLE);
  assign in_acc               = in_valid && in_ready;
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_poisoned_address = out_addr_r;

  // Write port: zero during the clearing pass, fill value during a fill.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_idx_r;
    ram_wdata = fill_val_r;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else if (state_r == S_FILL) begin
      ram_we    = 1'b1;
    end
  end

  // Range checks on the registered offsets, alignment check on the registered addresses.
  assign off_l   = off_e_r - smpc_pkg::ADDR_W'(smpc_pkg::GRANULE_BYTES);
  assign a_in    = (off_a_r[smpc_pkg::ADDR_W-1:smpc_pkg::WIN_W] == '0);
  assign e_in    = (off_e_r[smpc_pkg::ADDR_W-1:smpc_pkg::WIN_W] == '0);
  assign l_in    = (off_l[smpc_pkg::ADDR_W-1:smpc_pkg::WIN_W] == '0);
  assign aligned = (req_addr_r[smpc_pkg::GRAN_W-1:0] == '0) &&
                   (end_r[smpc_pkg::GRAN_W-1:0] == '0);

  // Bytes of the remaining range that fall in the granule being issued.
  assign room     = smpc_pkg::CNT_W'(smpc_pkg::GRANULE_BYTES) -
                    {1'b0, iss_off_r[smpc_pkg::GRAN_W-1:0]};
  assign rem_fits = (iss_rem_r <= {{(smpc_pkg::LEN_W - smpc_pkg::CNT_W){1'b0}}, room});
  assign cnt      = rem_fits ? iss_rem_r[smpc_pkg::CNT_W-1:0] : room;

  assign gt_req.shadow = $signed(ram_rdata);
  assign gt_req.pos0   = t_addr_r[smpc_pkg::GRAN_W-1:0];
  assign gt_req.cnt    = t_cnt_r;

  always_comb begin
    state_nxt       = state_r;
    window_base_nxt = cfg_wr_en ? cfg_wr_data : window_base_r;
    clr_idx_nxt     = clr_idx_r;
    req_op_nxt      = req_op_r;
    req_addr_nxt    = req_addr_r;
    req_len_nxt     = req_len_r;
    req_pv_nxt      = req_pv_r;
    off_a_nxt       = off_a_r;
    end_nxt         = end_r;
    off_e_nxt       = off_e_r;
    fill_idx_nxt    = fill_idx_r;
    fill_cnt_nxt    = fill_cnt_r;
    fill_val_nxt    = fill_val_r;
    iss_addr_nxt    = iss_addr_r;
    iss_off_nxt     = iss_off_r;
    iss_rem_nxt     = iss_rem_r;
    t_valid_nxt     = 1'b0;
    t_addr_nxt      = t_addr_r;
    t_cnt_nxt       = t_cnt_r;
    t_last_nxt      = t_last_r;
    res_status_nxt  = res_status_r;
    res_addr_nxt    = res_addr_r;
    // Drop the output item once taken.
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_addr_nxt    = out_addr_r;

    case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + smpc_pkg::IDX_W'(1);
        if (clr_idx_r == smpc_pkg::IDX_W'(smpc_pkg::DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_op_nxt   = in_operation;
          req_addr_nxt = in_address;
          req_len_nxt  = in_length;
          req_pv_nxt   = in_poison_value;
          state_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        off_a_nxt = req_addr_r - window_base_r;
        end_nxt   = req_addr_r + {{(smpc_pkg::ADDR_W - smpc_pkg::LEN_W){1'b0}}, req_len_r};
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        off_e_nxt = end_r - window_base_r;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        res_addr_nxt   = '0;
        res_status_nxt = smpc_pkg::ST_OK;
        state_nxt      = S_RESP;
        case (req_op_r)
          smpc_pkg::OP_POISON, smpc_pkg::OP_UNPOISON: begin
            fill_idx_nxt = off_a_r[smpc_pkg::WIN_W-1:smpc_pkg::GRAN_W];
            fill_cnt_nxt = req_len_r[smpc_pkg::LEN_W-1:smpc_pkg::GRAN_W];
            fill_val_nxt = (req_op_r == smpc_pkg::OP_POISON) ? req_pv_r : '0;
            if (!aligned || !a_in || !l_in) begin
              res_status_nxt = smpc_pkg::ST_REJECT;
            end else if (req_len_r[smpc_pkg::LEN_W-1:smpc_pkg::GRAN_W] != '0) begin
              state_nxt = S_FILL;
            end
          end
          smpc_pkg::OP_CHECK: begin
            iss_addr_nxt = req_addr_r;
            iss_off_nxt  = off_a_r[smpc_pkg::WIN_W-1:0];
            iss_rem_nxt  = req_len_r;
            if ((req_len_r != '0) && a_in && e_in) begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_FILL: begin
        // Write one shadow entry a cycle.
        fill_idx_nxt = fill_idx_r + smpc_pkg::IDX_W'(1);
        fill_cnt_nxt = fill_cnt_r - smpc_pkg::FCNT_W'(1);
        if (fill_cnt_r == smpc_pkg::FCNT_W'(1)) begin
          state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        // Issue: read the next entry while the previous one is tested.
        if (iss_rem_r != '0) begin
          t_valid_nxt  = 1'b1;
          t_addr_nxt   = iss_addr_r;
          t_cnt_nxt    = cnt;
          t_last_nxt   = rem_fits;
          iss_addr_nxt = iss_addr_r +
                         {{(smpc_pkg::ADDR_W - smpc_pkg::CNT_W){1'b0}}, cnt};
          iss_off_nxt  = iss_off_r +
                         {{(smpc_pkg::WIN_W - smpc_pkg::CNT_W){1'b0}}, cnt};
          iss_rem_nxt  = iss_rem_r -
                         {{(smpc_pkg::LEN_W - smpc_pkg::CNT_W){1'b0}}, cnt};
        end
        // Test: stop at the first poisoned byte or after the last entry.
        if (t_valid_r && gt_res.hit) begin
          res_status_nxt = smpc_pkg::ST_FOUND;
          res_addr_nxt   = t_addr_r +
                           {{(smpc_pkg::ADDR_W - smpc_pkg::GRAN_W){1'b0}}, gt_res.idx};
          t_valid_nxt    = 1'b0;
          state_nxt      = S_RESP;
        end else if (t_valid_r && t_last_r) begin
          t_valid_nxt    = 1'b0;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_op_r     <= req_op_nxt;
    req_addr_r   <= req_addr_nxt;
    req_len_r    <= req_len_nxt;
    req_pv_r     <= req_pv_nxt;
    off_a_r      <= off_a_nxt;
    end_r        <= end_nxt;
    off_e_r      <= off_e_nxt;
    fill_idx_r   <= fill_idx_nxt;
    fill_cnt_r   <= fill_cnt_nxt;
    fill_val_r   <= fill_val_nxt;
    iss_addr_r   <= iss_addr_nxt;
    iss_off_r    <= iss_off_nxt;
    iss_rem_r    <= iss_rem_nxt;
    t_addr_r     <= t_addr_nxt;
    t_cnt_r      <= t_cnt_nxt;
    t_last_r     <= t_last_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_idx_r     <= '0;
      window_base_r <= '0;
      t_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      window_base_r <= window_base_nxt;
      t_valid_r     <= t_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  `SMPC_ASSERT_IMPL(a_addr_zero_unless_found, clk, rst_n,
    out_valid_r && (out_status_r != smpc_pkg::ST_FOUND), out_addr_r == '0,
    "poisoned address nonzero without a find")
  `SMPC_ASSERT_IMPL(a_no_write_in_scan, clk, rst_n,
    state_r == S_SCAN, !ram_we, "shadow write during a check walk")
  `SMPC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
    in_acc, !in_ready, "item taken while the previous one is in work")
  `SMPC_ASSERT_IMPL(a_test_only_in_scan, clk, rst_n,
    t_valid_r, state_r == S_SCAN, "granule test outside a check walk")
  `SMPC_ASSERT_IMPL(a_fill_count_live, clk, rst_n,
    state_r == S_FILL, fill_cnt_r != '0, "fill walk with no entries left")

endmodule

// ----- dv/tb_shadow_memory_poison_checker_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for shadow_memory_poison_checker_unit: directed granule and window
// cases, then randomized poison, unpoison and check traffic under several idling mixes.
// Depends on smpc_pkg and the design sources only.
module tb_shadow_memory_poison_checker_unit;

  // The fourth operation code has no name in the package; the block must answer it as done.
  localparam logic [smpc_pkg::OP_W-1:0]   OP_SPARE  = 2'd3;
  localparam logic [smpc_pkg::ADDR_W-1:0] WIN_SPAN  =
    smpc_pkg::ADDR_W'(smpc_pkg::WINDOW_BYTES);
  localparam logic [smpc_pkg::ADDR_W-1:0] GRAN_SPAN =
    smpc_pkg::ADDR_W'(smpc_pkg::GRANULE_BYTES);
  localparam logic [smpc_pkg::LEN_W-1:0]  FULL_LEN  =
    smpc_pkg::LEN_W'(smpc_pkg::WINDOW_BYTES);
  localparam int                ZONE_BYTES       = 512;
  localparam int                ZONE_GRANULES    = ZONE_BYTES / smpc_pkg::GRANULE_BYTES;
  localparam int                SETTLE_CYCLES    = 16;
  localparam int                REPORT_LIMIT     = 10;
  localparam int                RANDOM_PER_PHASE = 256;
  // Time limit for the clearing pass, three whole-window walks and the random traffic,
  // with a wide margin.
  localparam longint            RUN_LIMIT_NS     = 64'd60_000_000;

  typedef struct {
    logic [smpc_pkg::ST_W-1:0]   status;
    logic [smpc_pkg::ADDR_W-1:0] where_hit;
  } verdict_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                              clk;
  logic                              rst_n           = 1'b0;
  logic                              cfg_wr_en       = 1'b0;
  logic [smpc_pkg::ADDR_W-1:0]       cfg_wr_data     = '0;
  logic                              in_valid        = 1'b0;
  logic                              in_ready;
  logic [smpc_pkg::OP_W-1:0]         in_operation    = smpc_pkg::OP_CHECK;
  logic [smpc_pkg::ADDR_W-1:0]       in_address      = '0;
  logic [smpc_pkg::LEN_W-1:0]        in_length       = '0;
  logic signed [smpc_pkg::VAL_W-1:0] in_poison_value = '0;
  logic                              out_valid;
  logic                              out_ready       = 1'b0;
  logic [smpc_pkg::ST_W-1:0]         out_status;
  logic [smpc_pkg::ADDR_W-1:0]       out_poisoned_address;

  // Predictor state: our own copy of the window base and of the shadow bytes.
  logic [smpc_pkg::ADDR_W-1:0]       win_base;
  logic signed [smpc_pkg::VAL_W-1:0] shadow_copy [smpc_pkg::DEPTH];
  verdict_t                          pending_verdicts [$];
  verdict_t                          oldest_verdict;

  int                          send_idle_pct = 0;
  int                          stall_pct     = 0;
  int unsigned                 zone_mid      = 0;
  int                          items_accepted = 0;
  int                          hits_seen      = 0;
  int                          rejects_seen   = 0;
  int                          mismatch_count = 0;
  int                          bases_used     = 0;

  shadow_memory_poison_checker_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_address           (in_address),
    .in_length            (in_length),
    .in_poison_value      (in_poison_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_poisoned_address (out_poisoned_address)
  );

  // 12 ns period, low half first.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------------------
  // Shadow predictor
  // ---------------------------------------------------------------------------------------

  // An address belongs to the window when its offset from the base, modulo 2^64, is small.
  function automatic bit covers(input logic [smpc_pkg::ADDR_W-1:0] addr);
    logic [smpc_pkg::ADDR_W-1:0] off;
    off = addr - win_base;
    return off < WIN_SPAN;
  endfunction

  // Shadow entry that holds an address; outside the window fall back to entry zero.
  function automatic int granule_of(input logic [smpc_pkg::ADDR_W-1:0] addr);
    logic [smpc_pkg::ADDR_W-1:0] off;
    off = addr - win_base;
    return covers(addr) ? int'(off >> smpc_pkg::GRAN_W) : 0;
  endfunction

  // Apply one item to the shadow copy and return the status and address it must produce.
  function automatic verdict_t apply_shadow_op(
    input logic [smpc_pkg::OP_W-1:0]         op,
    input logic [smpc_pkg::ADDR_W-1:0]       addr,
    input logic [smpc_pkg::LEN_W-1:0]        len,
    input logic signed [smpc_pkg::VAL_W-1:0] value
  );
    verdict_t                          r;
    logic [smpc_pkg::ADDR_W-1:0]       stop;
    logic [smpc_pkg::ADDR_W-1:0]       last;
    logic [smpc_pkg::ADDR_W-1:0]       cur;
    logic signed [smpc_pkg::VAL_W-1:0] fill;
    int                                lo;
    int                                hi;
    int                                shadow_val;
    int                                pos;
    r.status    = smpc_pkg::ST_OK;
    r.where_hit = '0;
    stop = addr + smpc_pkg::ADDR_W'(len);
    last = stop - GRAN_SPAN;
    case (op)
      smpc_pkg::OP_POISON, smpc_pkg::OP_UNPOISON: begin
        fill = (op == smpc_pkg::OP_POISON) ? value : smpc_pkg::VAL_W'(0);
        // Both ends granule aligned, first and last granule inside the window.
        if (addr[smpc_pkg::GRAN_W-1:0] != '0 || stop[smpc_pkg::GRAN_W-1:0] != '0 ||
            !covers(addr) || !covers(last)) begin
          r.status = smpc_pkg::ST_REJECT;
        end else begin
          lo = granule_of(addr);
          hi = granule_of(last);
          for (int i = lo; i <= hi; i++) shadow_copy[i] = fill;
        end
      end
      smpc_pkg::OP_CHECK: begin
        // Exclusive end: the end address itself must still lie in the window.
        if (len != '0 && covers(addr) && covers(stop)) begin
          cur = addr;
          while (cur != stop && r.status == smpc_pkg::ST_OK) begin
            shadow_val = int'(shadow_copy[granule_of(cur)]);
            pos        = int'(cur[smpc_pkg::GRAN_W-1:0]);
            if (shadow_val != 0 && pos >= shadow_val) begin
              r.status    = smpc_pkg::ST_FOUND;
              r.where_hit = cur;
            end
            cur = cur + 64'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predict at the accepting edge; all sampled values are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_verdicts.push_back(apply_shadow_op(in_operation, in_address, in_length,
                                                 in_poison_value));
      items_accepted++;
    end
  end

  // Receiver: stall at the rate the current phase asks for.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare every accepted result with the oldest prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] unexpected result: status %0d address %h", $time, out_status,
                   out_poisoned_address);
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (oldest_verdict.status == smpc_pkg::ST_FOUND) hits_seen++;
        if (oldest_verdict.status == smpc_pkg::ST_REJECT) rejects_seen++;
        if (out_status !== oldest_verdict.status ||
            out_poisoned_address !== oldest_verdict.where_hit) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] result mismatch: status exp %0d got %0d, address exp %h got %h",
                     $time, oldest_verdict.status, out_status, oldest_verdict.where_hit,
                     out_poisoned_address);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Offer one item, after a random idle gap, and hold it until the block takes it.
  // Valid stays high on return so back-to-back items never drop it within one step.
  task automatic send_item(input logic [smpc_pkg::OP_W-1:0]         op,
                           input logic [smpc_pkg::ADDR_W-1:0]       addr,
                           input logic [smpc_pkg::LEN_W-1:0]        len,
                           input logic signed [smpc_pkg::VAL_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_address      <= addr;
    in_length       <= len;
    in_poison_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every predicted result, then let the block settle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the window base; only called while the block is idle.
  task automatic set_window_base(input logic [smpc_pkg::ADDR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_base   = value;
    bases_used++;
    @(posedge clk);
  endtask

  // One random item. Most traffic stays in three small zones of the window (bottom edge,
  // top edge, one spot in between) so checks keep running into earlier poison; some of it
  // is malformed, and the rest is out-of-window noise.
  task automatic send_random_item();
    int unsigned                       pick;
    int unsigned                       zone;
    logic [smpc_pkg::OP_W-1:0]         op;
    logic [smpc_pkg::ADDR_W-1:0]       addr;
    logic [smpc_pkg::LEN_W-1:0]        len;
    logic signed [smpc_pkg::VAL_W-1:0] value;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       zone = 0;
      1:       zone = smpc_pkg::WINDOW_BYTES - ZONE_BYTES;
      default: zone = zone_mid;
    endcase
    // Favor shadow values that split a granule, but cover negatives and the full byte.
    case ($urandom_range(0, 3))
      0, 1:    value = smpc_pkg::VAL_W'($urandom_range(1, smpc_pkg::GRANULE_BYTES - 1));
      2:       value = smpc_pkg::VAL_W'(-int'($urandom_range(1, 128)));
      default: value = smpc_pkg::VAL_W'($urandom);
    endcase
    if (pick < 40) begin
      op   = (pick < 30) ? smpc_pkg::OP_POISON : smpc_pkg::OP_UNPOISON;
      addr = win_base + smpc_pkg::ADDR_W'(zone + smpc_pkg::GRANULE_BYTES *
                                          $urandom_range(0, ZONE_GRANULES - 1));
      len  = smpc_pkg::LEN_W'(smpc_pkg::GRANULE_BYTES * $urandom_range(0, 5));
    end else if (pick < 85) begin
      op   = smpc_pkg::OP_CHECK;
      addr = win_base + smpc_pkg::ADDR_W'(zone + $urandom_range(0, ZONE_BYTES - 1));
      len  = ($urandom_range(0, 15) == 0) ? smpc_pkg::LEN_W'(0) :
                                             smpc_pkg::LEN_W'($urandom_range(1, 40));
    end else if (pick < 93) begin
      // Misaligned or odd-length ranges inside the window, any operation.
      op   = smpc_pkg::OP_W'($urandom_range(0, 3));
      addr = win_base + smpc_pkg::ADDR_W'(zone + $urandom_range(0, ZONE_BYTES - 1));
      len  = smpc_pkg::LEN_W'($urandom_range(0, 40));
    end else begin
      // Anything the fields allow; such addresses almost never land in the window.
      op   = smpc_pkg::OP_W'($urandom_range(0, 3));
      addr = {$urandom, $urandom};
      len  = smpc_pkg::LEN_W'($urandom_range(0, smpc_pkg::WINDOW_BYTES));
    end
    send_item(op, addr, len, value);
  endtask

  task automatic run_traffic(input int count);
    zone_mid = smpc_pkg::GRANULE_BYTES *
               $urandom_range(1, (smpc_pkg::WINDOW_BYTES - 2 * ZONE_BYTES) /
                                 smpc_pkg::GRANULE_BYTES);
    repeat (count) send_random_item();
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Let the clearing pass finish, then program the base explicitly.
  task automatic test_after_reset();
    while (!in_ready) @(posedge clk);
    set_window_base('0);
  endtask

  // Partial granules, negative and oversized shadow values, unpoison.
  task automatic test_granule_rules();
    send_item(smpc_pkg::OP_CHECK, win_base, '0, '0);
    send_item(smpc_pkg::OP_POISON, win_base, smpc_pkg::LEN_W'(8), smpc_pkg::VAL_W'(3));
    send_item(smpc_pkg::OP_CHECK, win_base, smpc_pkg::LEN_W'(8), '0);
    send_item(smpc_pkg::OP_POISON, win_base + 64'd8, smpc_pkg::LEN_W'(16),
              smpc_pkg::VAL_W'(-128));
    send_item(smpc_pkg::OP_CHECK, win_base + 64'd9, smpc_pkg::LEN_W'(3), '0);
    send_item(smpc_pkg::OP_POISON, win_base + 64'd24, smpc_pkg::LEN_W'(8),
              smpc_pkg::VAL_W'(127));
    send_item(smpc_pkg::OP_CHECK, win_base + 64'd24, smpc_pkg::LEN_W'(8), '0);
    send_item(smpc_pkg::OP_UNPOISON, win_base, smpc_pkg::LEN_W'(24),
              smpc_pkg::VAL_W'(8'h55));
    send_item(smpc_pkg::OP_CHECK, win_base, smpc_pkg::LEN_W'(32), '0);
  endtask

  // Misaligned ends, zero length at and past the bottom, a range running off the top,
  // and a check starting below the window.
  task automatic test_rejected_ranges();
    send_item(smpc_pkg::OP_POISON, win_base + 64'd4, smpc_pkg::LEN_W'(8),
              smpc_pkg::VAL_W'(1));
    send_item(smpc_pkg::OP_UNPOISON, win_base, smpc_pkg::LEN_W'(12), '0);
    send_item(smpc_pkg::OP_POISON, win_base, '0, smpc_pkg::VAL_W'(2));
    send_item(smpc_pkg::OP_POISON, win_base + 64'd8, '0, smpc_pkg::VAL_W'(2));
    send_item(smpc_pkg::OP_POISON, win_base + WIN_SPAN - GRAN_SPAN, smpc_pkg::LEN_W'(16),
              smpc_pkg::VAL_W'(1));
    send_item(smpc_pkg::OP_CHECK, win_base - 64'd1, smpc_pkg::LEN_W'(4), '0);
  endtask

  // Top granule: a check ending exactly at the top is not walked and reports clean, one byte shorter hits.
  // Then the unused operation with address and value at their maximum and a whole-window length.
  task automatic test_window_top();
    send_item(smpc_pkg::OP_POISON, win_base + WIN_SPAN - GRAN_SPAN, smpc_pkg::LEN_W'(8),
              smpc_pkg::VAL_W'(1));
    send_item(smpc_pkg::OP_CHECK, win_base + WIN_SPAN - GRAN_SPAN, smpc_pkg::LEN_W'(8), '0);
    send_item(smpc_pkg::OP_CHECK, win_base + WIN_SPAN - GRAN_SPAN, smpc_pkg::LEN_W'(7), '0);
    send_item(OP_SPARE, '1, FULL_LEN, smpc_pkg::VAL_W'(127));
  endtask

  // Fill and clear the whole window, and walk all but its last byte once while clean.
  task automatic test_whole_window();
    send_item(smpc_pkg::OP_POISON, win_base, FULL_LEN, smpc_pkg::VAL_W'(-1));
    send_item(smpc_pkg::OP_CHECK, win_base, FULL_LEN - smpc_pkg::LEN_W'(1), '0);
    send_item(smpc_pkg::OP_CHECK, win_base + 64'd1, FULL_LEN, '0);
    send_item(smpc_pkg::OP_UNPOISON, win_base, FULL_LEN, smpc_pkg::VAL_W'(-1));
    send_item(smpc_pkg::OP_CHECK, win_base, FULL_LEN - smpc_pkg::LEN_W'(1), '0);
  endtask

  // Back-to-back traffic on a window that wraps past the top of the address space.
  task automatic test_stream_no_idle();
    wait_quiet();
    set_window_base(64'hFFFF_FFFF_FFFF_FFF8);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_traffic(RANDOM_PER_PHASE);
  endtask

  // Sparse sender on a random aligned base.
  task automatic test_sparse_sender();
    logic [smpc_pkg::ADDR_W-1:0] base;
    base = {$urandom, $urandom};
    base[smpc_pkg::GRAN_W-1:0] = '0;
    wait_quiet();
    set_window_base(base);
    send_idle_pct = 87;
    stall_pct     = 0;
    run_traffic(RANDOM_PER_PHASE);
  endtask

  // Slow receiver on a window that ends exactly at the top of the address space.
  task automatic test_slow_receiver();
    wait_quiet();
    set_window_base(64'hFFFF_FFFF_FFF0_0000);
    send_idle_pct = 0;
    stall_pct     = 87;
    run_traffic(RANDOM_PER_PHASE);
  endtask

  // Light idling on both sides, base with only the top bit set.
  task automatic test_both_sides_idle();
    wait_quiet();
    set_window_base(64'h8000_0000_0000_0000);
    send_idle_pct = 19;
    stall_pct     = 19;
    run_traffic(RANDOM_PER_PHASE);
  endtask

  initial begin
    win_base = '0;
    foreach (shadow_copy[i]) shadow_copy[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_granule_rules();
    test_rejected_ranges();
    test_window_top();
    test_whole_window();
    test_stream_no_idle();
    test_sparse_sender();
    test_slow_receiver();
    test_both_sides_idle();
    wait_quiet();

    $display("run covered %0d items over %0d window bases", items_accepted, bases_used);
    $display("results: %0d poisoned bytes found, %0d rejected ranges, %0d mismatches",
             hits_seen, rejects_seen, mismatch_count);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("shadow_memory_poison_checker_unit verification clean");
    end else begin
      $display("shadow_memory_poison_checker_unit verification failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", pending_verdicts.size());
    $display("shadow_memory_poison_checker_unit verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/smpc_pkg.sv
design/smpc_ram.sv
design/smpc_granule_test.sv
design/shadow_memory_poison_checker_unit.sv
dv/tb_shadow_memory_poison_checker_unit.sv
